FILE: rtl/core/i2cms_pkg.sv
package i2cms_pkg;

    localparam int BYTE_BITS = 8;
    localparam int BIT_CNT_W = $clog2(BYTE_BITS + 1);
    localparam int PHASE_W   = 3;

    localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd250;

    // Command codes as they arrive in the func field.
    localparam logic [2:0] FUNC_START = 3'd0;
    localparam logic [2:0] FUNC_STOP  = 3'd1;
    localparam logic [2:0] FUNC_WRITE = 3'd2;
    localparam logic [2:0] FUNC_WAIT  = 3'd3;
    localparam logic [2:0] FUNC_READ  = 3'd4;

    typedef enum logic [5:0] {
        CMD_IDLE  = 6'b000001,
        CMD_START = 6'b000010,
        CMD_STOP  = 6'b000100,
        CMD_WRITE = 6'b001000,
        CMD_WAIT  = 6'b010000,
        CMD_READ  = 6'b100000
    } cmd_t;

    typedef struct packed {
        logic                 cmd_valid;
        logic [2:0]           func;
        logic [BYTE_BITS-1:0] tx_byte;
        logic                 tx_ack;
        logic                 sda_in;
    } tick_t;

    typedef struct packed {
        logic                 scl;
        logic                 sda_out;
        logic                 sda_oe;
        logic                 busy_res;
        logic                 done_res;
        logic [BYTE_BITS-1:0] rx_byte;
        logic                 ack_error;
    } res_t;

endpackage

FILE: rtl/core/i2cms_in_reg.sv
module i2cms_in_reg
    import i2cms_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  tick_valid,
    output logic  tick_ready,
    input  tick_t tick,
    output logic  hold_valid,
    input  logic  hold_pop,
    output tick_t hold
);

    logic  valid_reg;
    tick_t data_reg;

    // The register takes a new transaction whenever it is empty or is being drained.
    assign tick_ready = !valid_reg || hold_pop;
    assign hold_valid = valid_reg;
    assign hold       = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (tick_ready)
        begin
            valid_reg <= tick_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_valid && tick_ready)
        begin
            data_reg <= tick;
        end
    end

endmodule

FILE: rtl/core/i2cms_engine.sv
module i2cms_engine
    import i2cms_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step_en,
    input  tick_t      item,
    input  logic [7:0] ack_timeout,
    output res_t       result
);

    cmd_t                 cmd_reg, cmd_next;
    logic [PHASE_W-1:0]   phase_reg, phase_next;
    logic [BIT_CNT_W-1:0] bit_reg, bit_next;
    logic [BYTE_BITS-1:0] shift_reg, shift_next;
    logic [7:0]           wait_reg, wait_next;
    logic                 scl_reg, scl_next;
    logic                 sda_reg, sda_next;
    logic                 oe_reg, oe_next;
    logic                 fail_reg, fail_next;
    logic [BYTE_BITS-1:0] rx_reg, rx_next;
    logic                 busy, fin;
    logic                 stop_do;
    logic [PHASE_W-1:0]   stop_k;

    always_comb
    begin
        cmd_next   = cmd_reg;
        phase_next = phase_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        wait_next  = wait_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        oe_next    = oe_reg;
        fail_next  = fail_reg;
        rx_next    = rx_reg;
        fin        = 1'b0;
        stop_do    = 1'b0;
        stop_k     = '0;

        // A command is taken only while idle; unknown func codes are dropped.
        if (cmd_reg == CMD_IDLE && item.cmd_valid)
        begin
            case (item.func)
                FUNC_START: cmd_next = CMD_START;
                FUNC_STOP:  cmd_next = CMD_STOP;
                FUNC_WRITE: cmd_next = CMD_WRITE;
                FUNC_WAIT:  cmd_next = CMD_WAIT;
                FUNC_READ:  cmd_next = CMD_READ;
                default:    cmd_next = CMD_IDLE;
            endcase
            phase_next = '0;
            bit_next   = '0;
            case (cmd_next)
                CMD_WRITE: shift_next = item.tx_byte;
                CMD_WAIT:  fail_next  = 1'b0;
                CMD_READ:
                begin
                    shift_next = '0;
                    sda_next   = item.tx_ack;
                end
                default: ;
            endcase
        end

        busy = (cmd_next != CMD_IDLE);

        case (cmd_next)
            CMD_START:
            begin
                case (phase_next)
                    3'd0: scl_next = 1'b0;
                    3'd1:
                    begin
                        oe_next  = 1'b1;
                        sda_next = 1'b1;
                    end
                    3'd2: scl_next = 1'b1;
                    3'd3: sda_next = 1'b0;
                    default:
                    begin
                        scl_next = 1'b0;
                        fin      = 1'b1;
                    end
                endcase
                phase_next = phase_next + 3'd1;
            end
            CMD_STOP:
            begin
                stop_do    = 1'b1;
                stop_k     = phase_next;
                phase_next = phase_next + 3'd1;
            end
            CMD_WRITE:
            begin
                case (phase_next)
                    3'd0:
                    begin
                        scl_next   = 1'b0;
                        oe_next    = 1'b1;
                        phase_next = 3'd1;
                    end
                    3'd1:
                    begin
                        sda_next   = shift_next[BYTE_BITS-1];
                        phase_next = 3'd2;
                    end
                    3'd2:
                    begin
                        scl_next   = 1'b1;
                        phase_next = 3'd3;
                    end
                    default:
                    begin
                        scl_next   = 1'b0;
                        shift_next = {shift_next[BYTE_BITS-2:0], 1'b0};
                        bit_next   = bit_next + BIT_CNT_W'(1);
                        if (bit_next >= BIT_CNT_W'(BYTE_BITS))
                        begin
                            fin = 1'b1;
                        end
                        else
                        begin
                            phase_next = 3'd1;
                        end
                    end
                endcase
            end
            CMD_WAIT:
            begin
                case (phase_next)
                    3'd0:
                    begin
                        scl_next   = 1'b0;
                        oe_next    = 1'b0;
                        sda_next   = 1'b1;
                        phase_next = 3'd1;
                    end
                    3'd1:
                    begin
                        scl_next   = 1'b1;
                        wait_next  = '0;
                        phase_next = 3'd2;
                    end
                    3'd2:
                    begin
                        if (!item.sda_in)
                        begin
                            scl_next = 1'b0;
                            fin      = 1'b1;
                        end
                        else
                        begin
                            wait_next = wait_next + 8'd1;
                            if (wait_next >= ack_timeout)
                            begin
                                fail_next  = 1'b1;
                                phase_next = 3'd3;
                            end
                        end
                    end
                    default:
                    begin
                        // Timed out: run the stop sequence from phase three on.
                        stop_do    = 1'b1;
                        stop_k     = phase_next - 3'd3;
                        phase_next = phase_next + 3'd1;
                    end
                endcase
            end
            CMD_READ:
            begin
                case (phase_next)
                    3'd0:
                    begin
                        scl_next   = 1'b0;
                        oe_next    = 1'b0;
                        phase_next = 3'd1;
                    end
                    3'd1:
                    begin
                        scl_next   = 1'b1;
                        phase_next = 3'd2;
                    end
                    3'd2:
                    begin
                        shift_next = {shift_next[BYTE_BITS-2:0], item.sda_in};
                        scl_next   = 1'b0;
                        bit_next   = bit_next + BIT_CNT_W'(1);
                        phase_next = (bit_next >= BIT_CNT_W'(BYTE_BITS)) ? 3'd3 : 3'd1;
                    end
                    3'd3:
                    begin
                        oe_next    = 1'b1;
                        phase_next = 3'd4;
                    end
                    3'd4:
                    begin
                        scl_next   = 1'b1;
                        phase_next = 3'd5;
                    end
                    default:
                    begin
                        scl_next = 1'b0;
                        rx_next  = shift_next;
                        fin      = 1'b1;
                    end
                endcase
            end
            default: ;
        endcase

        if (stop_do)
        begin
            case (stop_k)
                3'd0: scl_next = 1'b0;
                3'd1:
                begin
                    oe_next  = 1'b1;
                    sda_next = 1'b0;
                end
                3'd2: scl_next = 1'b1;
                default:
                begin
                    sda_next = 1'b1;
                    fin      = 1'b1;
                end
            endcase
        end

        if (fin)
        begin
            cmd_next   = CMD_IDLE;
            phase_next = '0;
            bit_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg   <= CMD_IDLE;
            phase_reg <= '0;
            bit_reg   <= '0;
            shift_reg <= '0;
            wait_reg  <= '0;
            scl_reg   <= 1'b0;
            sda_reg   <= 1'b0;
            oe_reg    <= 1'b1;
            fail_reg  <= 1'b0;
            rx_reg    <= '0;
        end
        else if (step_en)
        begin
            cmd_reg   <= cmd_next;
            phase_reg <= phase_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
            wait_reg  <= wait_next;
            scl_reg   <= scl_next;
            sda_reg   <= sda_next;
            oe_reg    <= oe_next;
            fail_reg  <= fail_next;
            rx_reg    <= rx_next;
        end
    end

    always_comb
    begin
        result.scl       = scl_next;
        result.sda_out   = sda_next;
        result.sda_oe    = oe_next;
        result.busy_res  = busy;
        result.done_res  = fin;
        result.rx_byte   = rx_next;
        result.ack_error = fail_next;
    end

endmodule

FILE: rtl/core/i2c_master_bit_sequencer.sv
// I2C master line sequencer, stepped by one half-bit tick per input transaction.
// Input channel (tick_valid / tick_ready / tick): each transaction carries the sampled
// SDA level and, when the sequencer is idle, an optional command (start, stop, write
// byte, wait for acknowledge, read byte with a trailing ACK or NACK bit).
// Output channel (res_valid / res_ready / res): exactly one result transaction per
// input transaction, in order, giving the SCL and SDA drive levels, busy and done
// flags, the last received byte and the acknowledge-failure flag.
// Configuration: cfg_we writes cfg_wdata into the acknowledge timeout (in ticks);
// write it only while no transaction is in flight.
// A transaction is captured in the input register; once the result slot is free the
// sequencer steps and the result register is loaded. Throughput is one transaction per
// cycle while the receiver takes each result without stalling.
// Reset clears both valid flags, drives SCL low with SDA driven low, clears the state
// machine to idle and loads the timeout with 250.
// When the receiver stalls, the result is held, the input register keeps at most one
// more transaction, and tick_ready drops until the result is taken.
module i2c_master_bit_sequencer
    import i2cms_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       tick_valid,
    output logic       tick_ready,
    input  tick_t      tick,
    output logic       res_valid,
    input  logic       res_ready,
    output res_t       res,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata
);

    logic       hold_valid;
    logic       advance;
    tick_t      hold;
    res_t       step_res;
    logic       res_valid_reg;
    res_t       res_reg;
    logic [7:0] timeout_reg;

    // The state machine steps whenever a captured tick exists and the result slot frees.
    assign advance = hold_valid && (!res_valid_reg || res_ready);

    i2cms_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick_valid (tick_valid),
        .tick_ready (tick_ready),
        .tick       (tick),
        .hold_valid (hold_valid),
        .hold_pop   (advance),
        .hold       (hold)
    );

    i2cms_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .step_en     (advance),
        .item        (hold),
        .ack_timeout (timeout_reg),
        .result      (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= ACK_TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            timeout_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    // The result payload only changes when a new step is loaded.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= step_res;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

FILE: rtl/core/i2cms_checker.sv
module i2cms_checker
    import i2cms_pkg::*;
(
    input logic  clk,
    input logic  rst_n,
    input logic  tick_ready,
    input logic  res_valid,
    input logic  res_ready,
    input res_t  res
);

    // A completing command is always reported as busy on its last tick.
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (!res.done_res || res.busy_res))
        else $error("done without busy");

    // With no result pending, the block must take a new tick.
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid |-> tick_ready)
        else $error("input stalled while output is empty");

    // No result can appear on the first edge after reset.
    a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> !res_valid)
        else $error("result right after reset");

    // A stalled result is held unchanged.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(res)))
        else $error("stalled result changed");

endmodule

bind i2c_master_bit_sequencer i2cms_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .tick_ready (tick_ready),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
);
